// ----- design/srm_pkg.sv -----
// Shared types and constants for the serial register access master.
`default_nettype none
package srm_pkg;

    localparam int BITS_PER_FIELD = 8;

    localparam int STEP_W  = 6;
    localparam int PHASE_W = 8;

    localparam logic [STEP_W-1:0] STEP_IDLE   = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_CLEAR  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_ENABLE = STEP_W'(2);
    localparam logic [STEP_W-1:0] ADDR_FIRST  = STEP_W'(3);
    localparam logic [STEP_W-1:0] ADDR_END    = STEP_W'(3 + 3 * BITS_PER_FIELD);
    localparam logic [STEP_W-1:0] WR_LAST     = STEP_W'(3 + 6 * BITS_PER_FIELD);
    localparam logic [STEP_W-1:0] RD_LAST     = STEP_W'(3 + 5 * BITS_PER_FIELD + 1);

    localparam logic [4:0] ADDR_MASK = 5'h1F;
    localparam logic [7:0] READ_FLAG = 8'h80;

    localparam int PIN_SEN   = 0;
    localparam int PIN_SCLK  = 1;
    localparam int PIN_SDATA = 2;

    localparam logic [1:0] SUB_DATA = 2'd0;
    localparam logic [1:0] SUB_RISE = 2'd1;
    localparam logic [1:0] SUB_FALL = 2'd2;

    localparam logic [PHASE_W-1:0] TICKS_RESET = PHASE_W'(4);

    typedef struct packed {
        logic [STEP_W-1:0]         step;
        logic [PHASE_W-1:0]        phase;
        logic [1:0]                sub;
        logic [BITS_PER_FIELD-1:0] shift_out;
        logic [BITS_PER_FIELD-1:0] shift_in;
        logic [2:0]                pins;
        logic                      is_read;
        logic                      dev;
        logic [BITS_PER_FIELD-1:0] held_data;
    } frame_state_t;

    typedef struct packed {
        logic                      req_valid;
        logic                      req_type;
        logic                      target_dev;
        logic [4:0]                reg_addr;
        logic [BITS_PER_FIELD-1:0] write_data;
        logic                      sdout_pin;
    } tick_in_t;

endpackage
`default_nettype wire

// ----- design/serial_register_access_master.sv -----
// Top level of the three-wire serial register master.
//
// Each request on the input channel is one tick: it carries the request fields and the sampled
// device output line. Every accepted tick yields exactly one result, registered and shown in
// the next cycle, and a new tick is taken every cycle while the result side keeps up; the pace is
// set by the single frame-state register updated once per tick. A frame runs 51 pin changes for
// a write and 44 for a read, each held ticks_per_phase ticks (zero counts as one); requests that
// arrive during a frame, including its final tick, are dropped. ticks_per_phase resets to 4.
`default_nettype none
module serial_register_access_master (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       req_valid,
    input  wire logic       req_type,
    input  wire logic       target_dev,
    input  wire logic [4:0] reg_addr,
    input  wire logic [7:0] write_data,
    input  wire logic       sdout_pin,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            sen_pin,
    output logic            sclk_pin,
    output logic            sdata_pin,
    output logic            pin_dev,
    output logic            busy_res,
    output logic            done_res,
    output logic [7:0]      read_data
);
    import srm_pkg::*;

    frame_state_t       state_reg;
    frame_state_t       state_next;
    tick_in_t           tick;
    logic [PHASE_W-1:0] ticks_reg;
    logic               done_reg;
    logic               done_next;
    logic               out_valid_reg;
    logic               accept;

    assign tick = '{req_valid: req_valid, req_type: req_type, target_dev: target_dev,
                    reg_addr: reg_addr, write_data: write_data, sdout_pin: sdout_pin};

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    srm_step u_step (
        .cur             (state_reg),
        .tick            (tick),
        .ticks_per_phase (ticks_reg),
        .nxt             (state_next),
        .done            (done_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= TICKS_RESET;
        end
        else if (cfg_wr_en)
        begin
            ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                done_reg  <= done_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign sen_pin   = state_reg.pins[PIN_SEN];
    assign sclk_pin  = state_reg.pins[PIN_SCLK];
    assign sdata_pin = state_reg.pins[PIN_SDATA];
    assign pin_dev   = state_reg.dev;
    assign busy_res  = (state_reg.step != STEP_IDLE);
    assign done_res  = done_reg;
    assign read_data = state_reg.shift_in;

endmodule
`default_nettype wire

// ----- design/srm_step.sv -----
// Next-state logic for one tick of a serial frame.
`default_nettype none
module srm_step (
    input  wire srm_pkg::frame_state_t      cur,
    input  wire srm_pkg::tick_in_t          tick,
    input  wire logic [srm_pkg::PHASE_W-1:0] ticks_per_phase,
    output srm_pkg::frame_state_t           nxt,
    output logic                            done
);
    import srm_pkg::*;

    logic [PHASE_W-1:0] hold;
    logic [PHASE_W-1:0] phase_inc;
    logic [STEP_W-1:0]  last;
    logic [STEP_W-1:0]  s;
    logic [1:0]         sub;
    logic [BITS_PER_FIELD-1:0] so;

    assign hold      = (ticks_per_phase == '0) ? PHASE_W'(1) : ticks_per_phase;
    assign phase_inc = cur.phase + PHASE_W'(1);
    assign last      = cur.is_read ? RD_LAST : WR_LAST;
    assign s         = cur.step + STEP_W'(1);
    assign sub       = (s == ADDR_FIRST || cur.sub == SUB_FALL) ? SUB_DATA : cur.sub + 2'd1;

    always_comb
    begin
        nxt  = cur;
        done = 1'b0;
        so   = cur.shift_out;
        if (cur.step == STEP_IDLE)
        begin
            if (tick.req_valid)
            begin
                nxt.is_read   = tick.req_type;
                nxt.dev       = tick.target_dev;
                nxt.held_data = tick.write_data;
                nxt.shift_out = {3'b000, tick.reg_addr & ADDR_MASK};
                if (tick.req_type)
                begin
                    nxt.shift_out = nxt.shift_out | READ_FLAG;
                    nxt.shift_in  = '0;
                end
                nxt.pins  = '0;
                nxt.phase = '0;
                nxt.sub   = SUB_DATA;
                nxt.step  = STEP_CLEAR;
            end
        end
        else if (phase_inc < hold)
        begin
            nxt.phase = phase_inc;
        end
        else
        begin
            nxt.phase = '0;
            if (cur.step >= last)
            begin
                nxt.step = STEP_IDLE;
                nxt.pins = '0;
                done     = 1'b1;
            end
            else
            begin
                nxt.step = s;
                nxt.sub  = sub;
                if (s == STEP_ENABLE)
                begin
                    nxt.pins[PIN_SEN] = 1'b1;
                end
                else if ((s >= ADDR_FIRST && s < ADDR_END)
                         || (!cur.is_read && s >= ADDR_END && s < WR_LAST))
                begin
                    if (s == ADDR_END)
                    begin
                        so = cur.held_data;
                    end
                    nxt.shift_out = so;
                    case (sub)
                        SUB_DATA: nxt.pins[PIN_SDATA] = so[BITS_PER_FIELD-1];
                        SUB_RISE: nxt.pins[PIN_SCLK]  = 1'b1;
                        default:
                        begin
                            nxt.pins[PIN_SCLK] = 1'b0;
                            nxt.shift_out      = {so[BITS_PER_FIELD-2:0], 1'b0};
                        end
                    endcase
                end
                else if (cur.is_read && s == ADDR_END)
                begin
                    nxt.pins[PIN_SDATA] = 1'b1;
                end
                else if (cur.is_read && s > ADDR_END && s < RD_LAST)
                begin
                    if (!s[0])
                    begin
                        nxt.shift_in       = {cur.shift_in[BITS_PER_FIELD-2:0], tick.sdout_pin};
                        nxt.pins[PIN_SCLK] = 1'b1;
                    end
                    else
                    begin
                        nxt.pins[PIN_SCLK] = 1'b0;
                    end
                end
                else
                begin
                    nxt.pins = '0;
                end
            end
        end
    end

endmodule
`default_nettype wire
